### rtl/tmlg_pkg.sv
// Package for the text-mode line generator: command codes, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tmlg_pkg;

   typedef enum logic [1:0] {
      CMD_LINE  = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_CELL  = 2'd2,
      CMD_FONT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_BACK_PORCH = 2'd0,
      REG_VISIBLE    = 2'd1,
      REG_COLS       = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINE
   } state_type;

   localparam int          LINE_W       = 10;
   localparam int          COL_W        = 5;
   localparam int          TROW_W       = 6;
   localparam int          FONT_AW      = 11;
   localparam logic [9:0]  BACK_PORCH_RST = 10'd35;
   localparam logic [9:0]  VISIBLE_RST    = 10'd480;
   localparam logic [4:0]  COLS_RST       = 5'd20;
   localparam logic [7:0]  SPACE_CHAR     = 8'h20;
   localparam logic [3:0]  TEXT_ROW_MASK  = 4'hF;

   typedef struct packed {
      logic clear;
      logic frame_start;
      logic cell_write;
      logic font_write;
      logic porch_dec;
      logic line_start;
      logic issue;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic porch_nz;
      logic lines_done;
      logic ncols_zero;
      logic col_last;
      logic pipe_empty;
      logic advance;
   } dp_stat_type;

endpackage

### rtl/tmlg_ctrl.sv
// Controller state machine of the text-mode line generator.
// Depends on tmlg_pkg; drives the datapath through ctrl_cmd_type.
module tmlg_ctrl
   import tmlg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_command,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   cmd_type   command;
   logic      accept;

   assign command = cmd_type'(req_command);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      accept     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // take an item only once earlier memory reads have left the pipeline
            req_tready = stat.pipe_empty;
            accept     = req_tvalid && stat.pipe_empty;
            if (accept) begin
               unique case (command)
                  CMD_FRAME: cmd.frame_start = 1'b1;
                  CMD_CELL:  cmd.cell_write  = 1'b1;
                  CMD_FONT:  cmd.font_write  = 1'b1;
                  CMD_LINE: begin
                     if (stat.porch_nz) begin
                        cmd.porch_dec = 1'b1;
                     end else if (!stat.lines_done) begin
                        cmd.line_start = 1'b1;
                        if (!stat.ncols_zero) begin
                           state_in = ST_LINE;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LINE: begin
            cmd.issue = 1'b1;
            if (stat.advance && stat.col_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

### rtl/tmlg_datapath.sv
// Datapath of the text-mode line generator: registers, counters, character
// and font memories, read pipeline and output register. Depends on tmlg_pkg.
module tmlg_datapath
   import tmlg_pkg::*;
#(
   parameter int COLS = 20,
   parameter int ROWS = 10
)
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic [9:0]   csr_data,
   input  logic [3:0]   text_row,
   input  logic [4:0]   text_col,
   input  logic [7:0]   char_code,
   input  logic [2:0]   glyph_row,
   input  logic [7:0]   glyph_bits,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   pixels,
   output logic [4:0]   column,
   output logic         last
);

   localparam int CELLS = ROWS * COLS;
   localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [7:0] char_mem [CELLS];
   logic [7:0] font_mem [2**FONT_AW];

   logic [LINE_W-1:0] bp_ff, vis_ff;
   logic [COL_W-1:0]  cols_ff;
   logic [LINE_W-1:0] porch_ff, line_ff, line_in;
   logic [TROW_W-1:0] trow_ff;
   logic [CAW-1:0]    clr_ff, rowbase_ff;
   logic [COL_W-1:0]  col_ff, ncols_ff, ncols;
   logic [2:0]        frow_ff;
   logic              blank_ff;

   logic              s1_valid_ff, s1_last_ff, s1_blank_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [7:0]        char_q_ff;
   logic              s2_valid_ff, s2_last_ff, s2_blank_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic [7:0]        font_q_ff;
   logic              out_valid_ff, out_last_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [7:0]        out_pix_ff;

   logic              advance, issue_go, cell_ok;
   logic [CAW-1:0]    cell_addr, read_addr;

   assign ncols     = (32'(cols_ff) > 32'(COLS)) ? COL_W'(COLS) : cols_ff;
   assign line_in   = line_ff + 1'b1;
   assign advance   = !out_valid_ff || rsp_tready;
   assign issue_go  = cmd.issue && advance;
   assign cell_ok   = (32'(text_row) < 32'(ROWS)) && (32'(text_col) < 32'(COLS));
   assign cell_addr = CAW'(32'(text_row) * COLS + 32'(text_col));
   assign read_addr = CAW'(32'(rowbase_ff) + 32'(col_ff));

   assign stat.clear_last = (32'(clr_ff) == CELLS - 1);
   assign stat.porch_nz   = (porch_ff != '0);
   assign stat.lines_done = (line_ff >= vis_ff);
   assign stat.ncols_zero = (ncols == '0);
   assign stat.col_last   = (col_ff == ncols_ff - 1'b1);
   assign stat.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign stat.advance    = advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff   <= BACK_PORCH_RST;
         vis_ff  <= VISIBLE_RST;
         cols_ff <= COLS_RST;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_BACK_PORCH: bp_ff   <= csr_data;
            REG_VISIBLE:    vis_ff  <= csr_data;
            REG_COLS:       cols_ff <= csr_data[COL_W-1:0];
            default: ;
         endcase
      end
   end

   // frame counters and line context
   always_ff @(posedge clock) begin
      if (reset) begin
         porch_ff <= '0;
         line_ff  <= '0;
         trow_ff  <= '0;
         clr_ff   <= '0;
         col_ff   <= '0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.frame_start) begin
            line_ff  <= '0;
            trow_ff  <= '0;
            porch_ff <= bp_ff;
         end
         if (cmd.porch_dec) begin
            porch_ff <= porch_ff - 1'b1;
         end
         if (cmd.line_start) begin
            line_ff <= line_in;
            if ((line_in[3:0] & TEXT_ROW_MASK) == '0) begin
               trow_ff <= trow_ff + 1'b1;
            end
            col_ff <= '0;
         end
         if (issue_go) begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // hold the context of the line being drawn
   always_ff @(posedge clock) begin
      if (cmd.line_start) begin
         ncols_ff   <= ncols;
         frow_ff    <= line_ff[3:1];
         blank_ff   <= !(32'(trow_ff) < 32'(ROWS));
         rowbase_ff <= CAW'(32'(trow_ff) * COLS);
      end
   end

   // character cells: cleared to spaces after reset
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         char_mem[clr_ff] <= SPACE_CHAR;
      end else if (cmd.cell_write && cell_ok) begin
         char_mem[cell_addr] <= char_code;
      end
      if (issue_go && !blank_ff) begin
         char_q_ff <= char_mem[read_addr];
      end
   end

   // font store
   always_ff @(posedge clock) begin
      if (cmd.font_write) begin
         font_mem[{glyph_row, char_code}] <= glyph_bits;
      end
      if (advance && s1_valid_ff && !s1_blank_ff) begin
         font_q_ff <= font_mem[{frow_ff, char_q_ff}];
      end
   end

   // read pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // read pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_col_ff   <= col_ff;
         s1_last_ff  <= stat.col_last;
         s1_blank_ff <= blank_ff;
         s2_col_ff   <= s1_col_ff;
         s2_last_ff  <= s1_last_ff;
         s2_blank_ff <= s1_blank_ff;
         out_col_ff  <= s2_col_ff;
         out_last_ff <= s2_last_ff;
         out_pix_ff  <= s2_blank_ff ? 8'h00 : font_q_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign pixels     = out_pix_ff;
   assign column     = out_col_ff;
   assign last       = out_last_ff;

endmodule

### rtl/text_mode_line_generator_unit.sv
// Top level of the text-mode line generator: controller plus datapath.
// Depends on tmlg_pkg, tmlg_ctrl and tmlg_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser command, tdata cell/font fields
//   rsp      out        rsp_tvalid/rsp_tready  tdata pixels/column, tlast
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A visible line event issues one column a cycle while the rsp channel does not
// stall, through a character read then a font read, both registered memory ports.
// After reset the character cells are cleared to spaces, one cell a cycle, with
// req_tready low. A stalled rsp channel freezes the read pipeline; the output
// register holds.
module text_mode_line_generator_unit
   import tmlg_pkg::*;
#(
   parameter int COLS = 20,
   parameter int ROWS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // [1:0] command
   // [3:0] text_row, [8:4] text_col, [16:9] char_code, [19:17] glyph_row,
   // [27:20] glyph_bits, [31:28] zero
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [7:0] pixels, [12:8] column, [15:13] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic [7:0]   pixels;
   logic [4:0]   column;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, column, pixels};

   tmlg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .stat        (stat),
      .cmd         (cmd)
   );

   tmlg_datapath #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .text_row   (req_tdata[3:0]),
      .text_col   (req_tdata[8:4]),
      .char_code  (req_tdata[16:9]),
      .glyph_row  (req_tdata[19:17]),
      .glyph_bits (req_tdata[27:20]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixels     (pixels),
      .column     (column),
      .last       (rsp_tlast)
   );

endmodule

### tb/tb_top.sv
// Self-checking bench for text_mode_line_generator_unit: a table of directed items, then
// frames of random line events, cell writes and font writes, checked column by column.
// Depends on tmlg_pkg and the RTL of text_mode_line_generator_unit.
module tb_top;
   import tmlg_pkg::*;

   localparam int COLS          = 20;
   localparam int ROWS          = 10;
   localparam int CELL_AW       = $clog2(ROWS * COLS);
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int STALL_LIMIT   = 3000;

   typedef struct packed {
      logic [7:0] pixels;
      logic [4:0] column;
      logic       last;
   } col_px_type;

   // One row of the directed table: an item or a register write.
   typedef struct packed {
      logic        is_reg;
      logic [1:0]  op;       // command, or register index
      logic [31:0] payload;  // packed request fields, or register value
      logic        typed;    // expected columns given in the row itself
      logic [4:0]  count;
      logic [7:0]  px;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = CMD_LINE;  // [1:0] command
   // [3:0] text_row, [8:4] text_col, [16:9] char_code, [19:17] glyph_row,
   // [27:20] glyph_bits, [31:28] zero
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;             // [7:0] pixels, [12:8] column, [15:13] zero
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_BACK_PORCH;
   logic [9:0]  csr_data = '0;

   // Predicted state of the generator
   logic [7:0]  glyph_img [0:2047];
   logic [7:0]  cell_img [0:ROWS*COLS-1];
   logic [9:0]  porch_left = '0;
   logic [9:0]  line_no = '0;
   logic [5:0]  text_row_now = '0;
   logic [9:0]  set_porch = BACK_PORCH_RST;
   logic [9:0]  set_visible = VISIBLE_RST;
   logic [4:0]  set_cols = COLS_RST;

   col_px_type  pending_columns [$];
   step_type    directed_steps [$];
   logic [7:0]  ready_codes [$];
   col_px_type  want;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          req_calm = 0;
   bit          rsp_hold_long = 1'b0;

   text_mode_line_generator_unit #(.COLS(COLS), .ROWS(ROWS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] pack_req(input logic [3:0] trow, input logic [4:0] tcol,
                                            input logic [7:0] code, input logic [2:0] grow,
                                            input logic [7:0] gbits);
      return {4'h0, gbits, grow, code, tcol, trow};
   endfunction

   function automatic void add_item(input cmd_type c, input logic [31:0] d, input logic typed,
                                    input logic [4:0] count, input logic [7:0] px);
      directed_steps.push_back({1'b0, c, d, typed, count, px});
   endfunction

   function automatic void add_reg(input reg_index_type idx, input logic [9:0] value);
      directed_steps.push_back({1'b1, idx, {22'd0, value}, 1'b0, 5'd0, 8'h00});
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Advance the predicted state by one accepted item; queue the columns it draws.
   task automatic render_item(input cmd_type c, input logic [31:0] d, input bit keep);
      int         ncols;
      logic [7:0] ch;
      col_px_type e;
      case (c)
         CMD_FRAME: begin
            line_no      = '0;
            text_row_now = '0;
            porch_left   = set_porch;
         end
         CMD_CELL: begin
            if (d[3:0] < ROWS && d[8:4] < COLS)
               cell_img[CELL_AW'(d[3:0] * COLS + d[8:4])] = d[16:9];
         end
         CMD_FONT: begin
            glyph_img[{d[19:17], d[16:9]}] = d[27:20];
         end
         default: begin
            if (porch_left != 0) begin
               porch_left = porch_left - 1'b1;
            end else if (line_no < set_visible) begin
               ncols = (set_cols > COLS) ? COLS : set_cols;
               for (int k = 0; k < ncols; k++) begin
                  e.pixels = 8'h00;
                  // rows below the text area draw blank
                  if (text_row_now < ROWS) begin
                     ch       = cell_img[CELL_AW'(text_row_now * COLS + k)];
                     e.pixels = glyph_img[{line_no[3:1], ch}];
                  end
                  e.column = 5'(k);
                  e.last   = (k == ncols - 1);
                  if (keep)
                     pending_columns.push_back(e);
               end
               line_no = line_no + 1'b1;
               if (line_no[3:0] == 4'd0)
                  text_row_now = text_row_now + 1'b1;
            end
         end
      endcase
   endtask

   // Offer one item, hold it until taken, then predict its columns.
   task automatic send_item(input cmd_type c, input logic [31:0] d, input bit typed,
                            input logic [4:0] count, input logic [7:0] px);
      int         gap;
      col_px_type e;
      if (req_calm > 0) begin
         req_calm--;
         gap = 0;
      end else begin
         gap = idle_gap();
         if ($urandom_range(0, 24) == 0)
            req_calm = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      render_item(c, d, !typed);
      if (typed) begin
         for (int k = 0; k < count; k++) begin
            e.pixels = px;
            e.column = 5'(k);
            e.last   = (k == count - 1);
            pending_columns.push_back(e);
         end
      end
   endtask

   // Write all eight rows of a glyph so that cells may use its code.
   task automatic load_glyph(input logic [7:0] code);
      for (int r = 0; r < 8; r++)
         send_item(CMD_FONT, pack_req(4'($urandom), 5'($urandom), code, 3'(r), 8'($urandom)),
                   1'b0, 0, 8'h00);
      ready_codes.push_back(code);
   endtask

   // Hold the sender until every column has arrived and the block has gone quiet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_columns.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [9:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_BACK_PORCH: set_porch = value;
         REG_VISIBLE:    set_visible = value;
         REG_COLS:       set_cols = value[4:0];
         default:        ;
      endcase
      @(posedge clock);
   endtask

   // Result side: random stalls, calm stretches, and one long hold on request
   initial begin
      int gap;
      int calm;
      calm = 0;
      @(posedge clock);
      forever begin
         if (rsp_hold_long) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_long = 1'b0;
         end
         if (calm > 0) begin
            calm--;
            gap = 0;
         end else begin
            gap = idle_gap();
            if ($urandom_range(0, 19) == 0)
               calm = $urandom_range(5, 20);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_columns.size() == 0) begin
            report_mismatch($sformatf("column %0d pixels %02h with nothing expected",
                                      rsp_tdata[12:8], rsp_tdata[7:0]));
         end else begin
            want = pending_columns.pop_front();
            if (rsp_tdata[7:0] !== want.pixels)
               report_mismatch($sformatf("pixels %02h, expected %02h (column %0d)",
                                         rsp_tdata[7:0], want.pixels, want.column));
            if (rsp_tdata[12:8] !== want.column)
               report_mismatch($sformatf("column %0d, expected %0d",
                                         rsp_tdata[12:8], want.column));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("tlast %b, expected %b (column %0d)",
                                         rsp_tlast, want.last, want.column));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("text_mode_line_generator_unit test failed");
         $finish;
      end
   end

   initial begin
      step_type   s;
      int         lines;
      int         pick;
      logic [9:0] porch_v;
      logic [9:0] vis_v;
      logic [4:0] cols_v;
      logic [7:0] code;

      foreach (cell_img[i])
         cell_img[i] = SPACE_CHAR;

      // Space glyph with known rows, covering the extremes of glyph_bits
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 0, 8'h00), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 1, 8'hFF), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 2, 8'h81), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 3, 8'h42), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 4, 8'h24), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 5, 8'h18), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 6, 8'hA5), 1, 0, 8'h00);
      add_item(CMD_FONT, pack_req(0, 0, SPACE_CHAR, 7, 8'h5A), 1, 0, 8'h00);
      // Out of reset: no porch, full width, blank cells
      add_item(CMD_LINE, 32'h0, 1, 20, 8'h00);
      add_item(CMD_LINE, 32'h0, 1, 20, 8'h00);   // same font row drawn twice
      add_item(CMD_LINE, 32'h0, 1, 20, 8'hFF);
      add_item(CMD_CELL, pack_req(0, 0, 8'hFF, 0, 8'h00), 1, 0, 8'h00);
      add_item(CMD_CELL, pack_req(9, 19, 8'h00, 7, 8'hFF), 1, 0, 8'h00);
      // Cell addresses off the screen are dropped
      add_item(CMD_CELL, pack_req(10, 0, 8'h00, 0, 8'h00), 1, 0, 8'h00);
      add_item(CMD_CELL, pack_req(15, 31, 8'hFF, 7, 8'hFF), 1, 0, 8'h00);
      add_item(CMD_CELL, pack_req(0, 20, 8'h00, 0, 8'h00), 1, 0, 8'h00);
      add_item(CMD_LINE, 32'h0, 0, 0, 8'h00);
      add_item(CMD_FRAME, 32'h0, 1, 0, 8'h00);
      add_item(CMD_LINE, 32'h0, 1, 0, 8'h00);    // back porch
      add_reg(REG_BACK_PORCH, 10'd1);
      add_reg(REG_VISIBLE, 10'd2);
      add_reg(REG_COLS, 10'd0);
      add_item(CMD_FRAME, 32'h0, 1, 0, 8'h00);
      add_item(CMD_LINE, 32'h0, 1, 0, 8'h00);    // back porch
      add_item(CMD_LINE, 32'h0, 1, 0, 8'h00);    // zero width still counts the line
      add_reg(REG_COLS, 10'd31);                 // saturates to full width
      add_item(CMD_LINE, 32'h0, 0, 0, 8'h00);
      add_item(CMD_LINE, 32'h0, 1, 0, 8'h00);    // past the visible lines

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      load_glyph(8'h00);
      load_glyph(8'hFF);

      foreach (directed_steps[i]) begin
         s = directed_steps[i];
         if (s.is_reg) begin
            wait_idle();
            write_reg(reg_index_type'(s.op), s.payload[9:0]);
         end else begin
            send_item(cmd_type'(s.op), s.payload, s.typed, s.count, s.px);
         end
      end
      ready_codes.push_back(SPACE_CHAR);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin porch_v = 10'd2;    vis_v = 10'd162;  cols_v = 5'd1;  lines = 165; end
            1: begin porch_v = 10'd1023; vis_v = 10'd1023; cols_v = 5'd31; lines = 5;   end
            2: begin porch_v = 10'd0;    vis_v = 10'd1023; cols_v = 5'd20; lines = 10;  end
            3: begin porch_v = 10'd3;    vis_v = 10'd0;    cols_v = 5'd5;  lines = 8;   end
            4: begin porch_v = 10'd0;    vis_v = 10'd6;    cols_v = 5'd0;  lines = 8;   end
            default: begin
               porch_v = 10'($urandom_range(0, 4));
               vis_v   = 10'($urandom_range(8, 12));
               cols_v  = 5'($urandom_range(1, 20));
               lines   = porch_v + vis_v + $urandom_range(0, 3);
            end
         endcase
         wait_idle();
         write_reg(REG_BACK_PORCH, porch_v);
         write_reg(REG_VISIBLE, vis_v);
         // upper data bits are beyond the register and must be dropped
         write_reg(REG_COLS, {5'($urandom), cols_v});
         if (ph == 2)
            rsp_hold_long = 1'b1;
         send_item(CMD_FRAME, $urandom & 32'h0FFF_FFFF, 1'b0, 0, 8'h00);
         for (int k = 0; k < lines; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               if ($urandom_range(0, 7) == 0) begin
                  code = 8'($urandom);
                  load_glyph(code);
               end else begin
                  code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
               end
               send_item(CMD_CELL, pack_req(4'($urandom_range(0, ROWS - 1)),
                                            5'($urandom_range(0, COLS - 1)),
                                            code, 3'($urandom), 8'($urandom)),
                         1'b0, 0, 8'h00);
            end else if (pick < 14) begin
               if ($urandom_range(0, 1) == 0)
                  send_item(CMD_CELL, pack_req(4'($urandom_range(ROWS, 15)), 5'($urandom),
                                               8'($urandom), 3'($urandom), 8'($urandom)),
                            1'b0, 0, 8'h00);
               else
                  send_item(CMD_CELL, pack_req(4'($urandom), 5'($urandom_range(COLS, 31)),
                                               8'($urandom), 3'($urandom), 8'($urandom)),
                            1'b0, 0, 8'h00);
            end else if (pick < 20) begin
               send_item(CMD_FONT, $urandom & 32'h0FFF_FFFF, 1'b0, 0, 8'h00);
            end else if (pick < 22) begin
               // restart the frame part way through
               send_item(CMD_FRAME, $urandom & 32'h0FFF_FFFF, 1'b0, 0, 8'h00);
            end
            send_item(CMD_LINE, $urandom & 32'h0FFF_FFFF, 1'b0, 0, 8'h00);
         end
      end

      wait_idle();
      if (mismatches == 0 && pending_columns.size() == 0)
         $display("text_mode_line_generator_unit test passed");
      else
         $display("text_mode_line_generator_unit test failed");
      $finish;
   end

endmodule
